// ----- sv/plst_pkg.sv -----
// Package for the positional list store: sizes, codes, cell control struct.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package plst_pkg;

  localparam int CAPACITY = 64;
  localparam int IDXW     = $clog2(CAPACITY);
  localparam int CNTW     = $clog2(CAPACITY + 1);
  localparam int CMPW     = (CNTW + 1 > 8) ? CNTW + 1 : 8;

  localparam int DATAW    = 32;
  localparam int OPW      = 2;
  localparam int POSW     = 7;
  localparam int STW      = 2;
  localparam int COUNTW   = 7;

  typedef enum logic [OPW-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [STW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic            ins_en;
    logic            del_en;
    logic [IDXW-1:0] at;
    logic [IDXW-1:0] rd_pos;
  } cell_ctrl_t;

  // Low bits of the element count as carried on the result channel.
  function automatic logic [COUNTW-1:0] to_count(input logic [CNTW-1:0] v);
    logic [CNTW+COUNTW-1:0] w;
    w = {{COUNTW{1'b0}}, v};
    return w[COUNTW-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/plst_if.sv -----
// Request and response channel interfaces of the positional list store.
// Depends on plst_pkg for field widths.
`default_nettype none

interface plst_req_if
  import plst_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [OPW-1:0]         op;
  logic signed [POSW-1:0] position;
  logic signed [DATAW-1:0] new_value;

  modport source (output valid, op, position, new_value, input ready);
  modport sink   (input valid, op, position, new_value, output ready);
endinterface

interface plst_rsp_if
  import plst_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [STW-1:0]          status;
  logic signed [DATAW-1:0] read_value;
  logic [COUNTW-1:0]       count;

  modport source (output valid, status, read_value, count, input ready);
  modport sink   (input valid, status, read_value, count, output ready);
endinterface

`default_nettype wire

// ----- sv/plst_cell.sv -----
// One storage cell of the list chain: holds one element and one read-chain stage.
// Depends on plst_pkg.
`default_nettype none

module plst_cell
  import plst_pkg::*;
(
  input  wire logic             clk_i,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire logic [IDXW-1:0]  idx_i,
  input  wire logic [DATAW-1:0] new_value_i,
  input  wire logic [DATAW-1:0] lower_i,
  input  wire logic [DATAW-1:0] upper_i,
  input  wire logic [DATAW-1:0] rd_i,
  output logic      [DATAW-1:0] value_o,
  output logic      [DATAW-1:0] rd_o
);

  logic [DATAW-1:0] val_q, val_d;
  logic [DATAW-1:0] rd_q, rd_d;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins_en) begin
      if (idx_i > ctrl_i.at) begin
        val_d = lower_i;
      end else if (idx_i == ctrl_i.at) begin
        val_d = new_value_i;
      end
    end else if (ctrl_i.del_en) begin
      if (idx_i >= ctrl_i.at) begin
        val_d = upper_i;
      end
    end
  end

  // Capture own element on a hit, else pass the upper neighbor's stage down.
  assign rd_d = (idx_i == ctrl_i.rd_pos) ? val_q : rd_i;

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rd_q  <= rd_d;
  end

  assign value_o = val_q;
  assign rd_o    = rd_q;

endmodule

`default_nettype wire

// ----- sv/positional_list_store.sv -----
// Top level of the positional list store: request decode, cell chain, result register.
// Depends on plst_pkg, plst_if (plst_req_if, plst_rsp_if) and plst_cell.
`default_nettype none

// The store keeps an ordered list of up to CAPACITY signed 32-bit elements in
// a row of cells. Insert puts new_value just after the given position (-1 is
// the front), delete removes the element at the position, read returns it.
// Insert and delete shift every affected cell by one in parallel, so these
// requests, and every request that ends in an error status, place their
// result in the output register in the cycle after the transaction. A read that
// is in range walks a read chain from the top cell down to cell 0, one cell
// per cycle, and its result is registered once that walk is done;
// the store takes no new request until that read has finished. A new request
// is taken in the same cycle as the pending result leaves. Cells beyond the
// element count hold stale data and are never returned.
module positional_list_store
  import plst_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  plst_req_if.sink    req_i,
  plst_rsp_if.source  rsp_o
);

  // State and bookkeeping
  state_e            st_q, st_d;
  logic [CNTW-1:0]   used_q, used_d;
  logic [CNTW-1:0]   rd_cnt_q, rd_cnt_d;
  logic [IDXW-1:0]   rd_pos_q;

  // Result register
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q;
  logic [DATAW-1:0]  out_value_q;
  logic [COUNTW-1:0] out_count_q;

  logic              accept;
  logic              go_read;
  logic              read_done;
  status_e           status;
  cell_ctrl_t        ctrl;

  logic signed [CMPW-1:0] p_ext, p1, n_ext;
  logic                   ins_rng_ok, pos_ok, full;

  // Cell chain wiring
  logic [DATAW-1:0] cell_val [CAPACITY];
  logic [DATAW-1:0] cell_rd  [CAPACITY];

  assign accept = req_i.valid && req_i.ready;

  // Range checks in a signed width that holds both the position and the count.
  assign p_ext      = CMPW'(req_i.position);
  assign p1         = p_ext + CMPW'(1);
  assign n_ext      = signed'(CMPW'(used_q));
  assign ins_rng_ok = (p1 >= CMPW'(0)) && (p1 <= n_ext);
  assign pos_ok     = (p_ext >= CMPW'(0)) && (p_ext < n_ext);
  assign full       = (used_q == CNTW'(CAPACITY));

  // Decode the request; shift only on an accepted transaction.
  always_comb begin
    ctrl        = '0;
    ctrl.rd_pos = rd_pos_q;
    status      = ST_RANGE;
    used_d      = used_q;
    go_read     = 1'b0;
    unique case (op_e'(req_i.op))
      OP_INSERT: begin
        if (ins_rng_ok) begin
          if (full) begin
            status = ST_FULL;
          end else begin
            status      = ST_OK;
            ctrl.ins_en = accept;
            ctrl.at     = p1[IDXW-1:0];
            if (accept) begin
              used_d = used_q + CNTW'(1);
            end
          end
        end
      end
      OP_DELETE: begin
        if (pos_ok) begin
          status      = ST_OK;
          ctrl.del_en = accept;
          ctrl.at     = p_ext[IDXW-1:0];
          if (accept) begin
            used_d = used_q - CNTW'(1);
          end
        end
      end
      OP_READ: begin
        if (pos_ok) begin
          status  = ST_OK;
          go_read = accept;
        end
      end
      default: begin
        // unused op code: range status, no change
      end
    endcase
  end

  // The read chain needs a steady read position; the read ends when rd_cnt_q reaches CAPACITY.
  assign read_done = (st_q == S_READ) && (rd_cnt_q == CNTW'(CAPACITY));

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: begin
        if (go_read) begin
          st_d = S_READ;
        end
      end
      S_READ: begin
        if (read_done) begin
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  // FSM outputs: take requests only when idle and the result slot frees up.
  always_comb begin
    req_i.ready = 1'b0;
    rd_cnt_d    = '0;
    unique case (st_q)
      S_IDLE: req_i.ready = !out_valid_q || rsp_o.ready;
      S_READ: rd_cnt_d    = rd_cnt_q + CNTW'(1);
      default: begin
        req_i.ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (accept && !go_read) begin
      out_valid_d = 1'b1;
    end else if (read_done) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && !rsp_o.ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      used_q      <= '0;
      rd_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      used_q      <= used_d;
      rd_cnt_q    <= rd_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load the result, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (go_read) begin
      rd_pos_q <= p_ext[IDXW-1:0];
    end
    if (accept && !go_read) begin
      out_status_q <= status;
      out_value_q  <= '0;
      out_count_q  <= to_count(used_d);
    end else if (read_done) begin
      out_status_q <= ST_OK;
      out_value_q  <= cell_rd[0];
      out_count_q  <= to_count(used_q);
    end
  end

  // Row of cells: each shifting cell takes its lower neighbor on insert, its upper
  // one on delete; every cell hands its read stage to the cell below every cycle.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATAW-1:0] lower, upper, rd_in;

    if (k == 0) begin : g_bottom
      assign lower = '0;
    end else begin : g_lower
      assign lower = cell_val[k-1];
    end

    if (k == CAPACITY - 1) begin : g_top
      assign upper = '0;
      assign rd_in = '0;
    end else begin : g_upper
      assign upper = cell_val[k+1];
      assign rd_in = cell_rd[k+1];
    end

    plst_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .idx_i       (IDXW'(k)),
      .new_value_i (req_i.new_value),
      .lower_i     (lower),
      .upper_i     (upper),
      .rd_i        (rd_in),
      .value_o     (cell_val[k]),
      .rd_o        (cell_rd[k])
    );
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.read_value = out_value_q;
  assign rsp_o.count      = out_count_q;

  // Checks
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNTW'(CAPACITY))
    else $error("element count above capacity");

  a_read_holds_list : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_READ) |=> $stable(used_q))
    else $error("list changed during a read");

  a_rsp_count_current : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.count == to_count(used_q)))
    else $error("pending result count differs from element count");

  a_read_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_read |=> (st_q == S_READ) && (rd_cnt_q == '0) && !rsp_o.valid)
    else $error("read did not start with an empty result slot");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for positional_list_store: directed and random insert, delete and
// read traffic, with every result checked against a list model kept in the bench.
// Depends on plst_pkg, plst_if and the positional_list_store top level.

module tb_top;
  import plst_pkg::*;

  // The op field has one code that the store does not use.
  localparam logic [OPW-1:0] OP_UNUSED = 2'd3;

  // Each random phase sends this many requests.
  localparam int TRAFFIC_ITEMS = 320;

  // Worst case is roughly 1600 requests, each an in-range read that walks the whole
  // cell chain, plus long sender gaps and receiver stalls. This is a few times that.
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    status_e                 status;
    logic signed [DATAW-1:0] read_value;
    logic [COUNTW-1:0]       count;
  } list_result_t;

  logic clk;
  logic rst_n;

  plst_req_if req ();
  plst_rsp_if rsp ();

  positional_list_store dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req.sink),
    .rsp_o  (rsp.source)
  );

  // Bench copy of the stored list, index 0 at the front.
  logic signed [DATAW-1:0] list_model[$];
  // Results predicted for accepted requests, oldest first.
  list_result_t            pending_results[$];

  int mismatches   = 0;
  int cycles       = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;

  always #4 clk = ~clk;

  // Hard stop in case the store hangs or drops a result.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[positional_list_store] ERROR");
      $finish;
    end
  end

  // Apply one request to the list model and return the result the store owes.
  // The range test comes first, so an insert at a bad position into a full
  // store reports a range error, not a full store.
  function automatic list_result_t apply_list_request(input logic [OPW-1:0] op,
                                                      input logic signed [POSW-1:0] pos,
                                                      input logic signed [DATAW-1:0] val);
    list_result_t r;
    int           p;
    int           n;
    p            = pos;
    n            = list_model.size();
    r.status     = ST_RANGE;
    r.read_value = '0;
    case (op)
      OP_INSERT: begin
        if (p >= -1 && p <= n - 1) begin
          if (n >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            list_model.insert(p + 1, val);
            r.status = ST_OK;
          end
        end
      end
      OP_DELETE: begin
        if (p >= 0 && p <= n - 1) begin
          list_model.delete(p);
          r.status = ST_OK;
        end
      end
      OP_READ: begin
        if (p >= 0 && p <= n - 1) begin
          r.read_value = list_model[p];
          r.status     = ST_OK;
        end
      end
      default: ;  // unused op: range status, no change
    endcase
    r.count = COUNTW'(list_model.size());
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint want_v, input longint got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
  endtask

  // Check every result transaction against the oldest prediction, then pick
  // the receiver's ready for the next cycle.
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result, status", -1, rsp.status);
      end else begin
        want = pending_results.pop_front();
        if (rsp.status !== want.status)
          flag_mismatch("status", want.status, rsp.status);
        if (rsp.read_value !== want.read_value)
          flag_mismatch("read_value", want.read_value, rsp.read_value);
        if (rsp.count !== want.count)
          flag_mismatch("count", want.count, rsp.count);
      end
    end
    rsp.ready <= rst_n && ($urandom_range(99) >= rx_stall_pct);
  end

  // Send one request: idle a random number of cycles with junk on the payload,
  // then hold valid until the transaction, then record the prediction.
  // Leaves valid high so back-to-back requests need no gap.
  task automatic send_request(input logic [OPW-1:0] op, input int pos,
                              input logic [DATAW-1:0] val);
    logic signed [POSW-1:0] pos_bits;
    pos_bits = POSW'(pos);
    while ($urandom_range(99) < tx_idle_pct) begin
      req.valid     <= 1'b0;
      req.op        <= OPW'($urandom);
      req.position  <= POSW'($urandom);
      req.new_value <= $urandom;
      @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.op        <= op;
    req.position  <= pos_bits;
    req.new_value <= val;
    do @(posedge clk); while (!req.ready);
    pending_results.push_back(apply_list_request(op, pos_bits, val));
  endtask

  // Drop valid and hold off until every predicted result has come back.
  task automatic wait_for_results();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Errors on an empty store: nothing to read or delete, only -1 is a valid
  // insert position.
  task automatic test_empty_store();
    send_request(OP_READ, 0, '0);
    send_request(OP_DELETE, 0, '0);
    send_request(OP_DELETE, -1, '0);
    send_request(OP_INSERT, 0, 32'h1234_5678);
    send_request(OP_INSERT, -2, 32'h1234_5678);
    send_request(OP_UNUSED, 0, 32'hFFFF_FFFF);
    send_request(OP_READ, 63, '0);
  endtask

  // Front, tail and middle positions with extreme values; reads at the
  // boundaries of the position field and just past the element count.
  task automatic test_edges();
    send_request(OP_INSERT, -1, 32'h7FFF_FFFF);
    send_request(OP_INSERT, 0, 32'h8000_0000);
    send_request(OP_INSERT, -1, 32'h0000_0000);
    send_request(OP_INSERT, 2, 32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++)
      send_request(OP_READ, i, '0);
    send_request(OP_READ, 4, '0);
    send_request(OP_READ, -1, '0);
    send_request(OP_READ, -64, '0);
    send_request(OP_INSERT, 63, 32'h5555_AAAA);
    send_request(OP_UNUSED, 1, 32'hAAAA_5555);
    send_request(OP_DELETE, 0, '0);
    send_request(OP_DELETE, 2, '0);
    send_request(OP_DELETE, 1, '0);
    send_request(OP_READ, 0, '0);
    send_request(OP_READ, 1, '0);
  endtask

  // Fill the store to capacity, probe the full cases, then empty it again.
  task automatic test_full_store();
    int victim;
    wait_for_results();
    while (list_model.size() < CAPACITY)
      send_request(OP_INSERT, int'($urandom_range(list_model.size())) - 1, $urandom);
    send_request(OP_INSERT, -1, $urandom);
    send_request(OP_INSERT, CAPACITY - 1, $urandom);
    // Bad position on a full store: range error wins.
    send_request(OP_INSERT, -2, $urandom);
    send_request(OP_READ, CAPACITY - 1, '0);
    send_request(OP_DELETE, CAPACITY - 1, '0);
    send_request(OP_INSERT, CAPACITY - 2, 32'h8000_0000);
    send_request(OP_READ, CAPACITY - 1, '0);
    while (list_model.size() > 0) begin
      victim = $urandom_range(list_model.size() - 1);
      if ($urandom_range(3) == 0)
        send_request(OP_READ, victim, '0);
      send_request(OP_DELETE, victim, '0);
    end
  endtask

  // Mostly in-range requests so the list grows, shrinks and fills up; the
  // insert share changes every 50 requests to sweep the count from empty to
  // full. A tenth of positions and a few op codes are pure noise.
  task automatic test_random_traffic(input int n_items);
    int               fill_bias;
    int               n;
    int               pos;
    logic [OPW-1:0]   op;
    logic [DATAW-1:0] val;
    fill_bias = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(3))
          0:       fill_bias = 20;
          1:       fill_bias = 50;
          2:       fill_bias = 75;
          default: fill_bias = 95;
        endcase
      end
      n = list_model.size();
      if ($urandom_range(99) < 3)
        op = OP_UNUSED;
      else if ($urandom_range(99) < fill_bias)
        op = OP_INSERT;
      else if ($urandom_range(1) == 0)
        op = OP_DELETE;
      else
        op = OP_READ;
      if ($urandom_range(9) == 0)
        pos = int'($urandom_range(127)) - 64;
      else if (op == OP_INSERT)
        pos = int'($urandom_range(n)) - 1;
      else if (n > 0)
        pos = $urandom_range(n - 1);
      else
        pos = 0;
      case ($urandom_range(15))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        2:       val = 32'h0000_0000;
        3:       val = 32'hFFFF_FFFF;
        default: val = $urandom;
      endcase
      send_request(op, pos, val);
    end
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    req.valid     = 1'b0;
    req.op        = OP_INSERT;
    req.position  = '0;
    req.new_value = '0;
    rsp.ready     = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // No idling on either side.
    test_empty_store();
    test_edges();
    test_full_store();
    test_random_traffic(TRAFFIC_ITEMS);

    // Sender mostly idle.
    wait_for_results();
    tx_idle_pct = 87;
    test_random_traffic(TRAFFIC_ITEMS);

    // Receiver mostly stalling.
    wait_for_results();
    tx_idle_pct  = 0;
    rx_stall_pct = 87;
    test_random_traffic(TRAFFIC_ITEMS);
    test_full_store();

    // Both sides idle a third of the time.
    wait_for_results();
    tx_idle_pct  = 35;
    rx_stall_pct = 35;
    test_random_traffic(TRAFFIC_ITEMS);

    // Drain, then give a slow read time to show up as a stray result.
    wait_for_results();
    repeat (CAPACITY + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[positional_list_store] OK");
    end else begin
      $display("[positional_list_store] ERROR");
    end
    $finish;
  end

endmodule
